// ===== hw/rtl/lcl_pkg.sv =====
// shared types, constants and helpers for the chaotic lfo
`timescale 1ns / 1ps
`default_nettype none
package lcl_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int STATE_WIDTH_DEF = 32;

	localparam int RATE_W     = 16;
	localparam int STEP_W     = 16;
	localparam int INITY_W    = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_ADDR_W = 1;
	localparam int LEVEL_W    = 8;
	localparam int DT_BITS    = 16;

	localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd655;
	localparam logic [INITY_W-1:0] INITY_RESET = 24'd655;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;

	// scaling constants in millionths
	localparam longint X_OFF_MICRO = 64'd19412596;
	localparam longint X_RNG_MICRO = 64'd38904618;
	localparam longint Y_OFF_MICRO = 64'd26754900;
	localparam longint Y_RNG_MICRO = 64'd53663078;
	localparam longint Z_RNG_MICRO = 64'd47866940;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_STEP_SIZE = 1'b0,
		CFG_INITIAL_Y = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MUL_XZ,
		OP_MUL_XY,
		OP_DIV3,
		OP_DT_X,
		OP_DT_Y,
		OP_DT_Z,
		OP_UPDATE,
		OP_LVL_X,
		OP_LVL_Y,
		OP_LVL_Z
	} op_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_MUL_XZ,
		CS_MUL_XY,
		CS_DIV3,
		CS_DT_X,
		CS_DT_Y,
		CS_DT_Z,
		CS_UPDATE,
		CS_LVL_X,
		CS_LVL_Y,
		CS_LVL_Z
	} ctrl_state_t;

	typedef struct packed {
		op_t  op;
		logic load;
		logic run;
		logic store;
		logic tick;
	} cmd_t;

	typedef struct packed {
		logic fire;
	} stat_t;

	// millionths to fixed point, rounded to nearest
	function automatic longint qmicro(input longint m, input int frac);
		return ((m <<< frac) + 64'sd500000) / 64'sd1000000;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lcl_ctrl.sv =====
// sequencer for one euler step and the output word handshake
`timescale 1ns / 1ps
`default_nettype none
module lcl_ctrl #(
	parameter int FRAC_BITS   = lcl_pkg::FRAC_BITS_DEF,
	parameter int STATE_WIDTH = lcl_pkg::STATE_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire lcl_pkg::stat_t stat,
	output lcl_pkg::cmd_t      cmd
);
	import lcl_pkg::*;

	localparam int LVL_BITS = FRAC_BITS + 6;
	localparam int MAXLEN   = (STATE_WIDTH > LVL_BITS) ? STATE_WIDTH : LVL_BITS;
	localparam int CW       = $clog2(MAXLEN + 2);

	ctrl_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] len;
	logic          last;
	logic          accept;
	logic          out_valid_q;

	always_comb begin
		case (state_q)
			CS_MUL_XZ, CS_MUL_XY, CS_DIV3: len = CW'(STATE_WIDTH);
			CS_DT_X, CS_DT_Y, CS_DT_Z: len = CW'(DT_BITS);
			CS_LVL_X, CS_LVL_Y, CS_LVL_Z: len = CW'(LVL_BITS);
			default:              len = '0;
		endcase
	end

	assign last   = (state_q != CS_IDLE) && (cnt_q == len + CW'(1));
	assign accept = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE:   if (accept && stat.fire) state_d = CS_MUL_XZ;
			CS_MUL_XZ: if (last) state_d = CS_MUL_XY;
			CS_MUL_XY: if (last) state_d = CS_DIV3;
			CS_DIV3:   if (last) state_d = CS_DT_X;
			CS_DT_X:   if (last) state_d = CS_DT_Y;
			CS_DT_Y:   if (last) state_d = CS_DT_Z;
			CS_DT_Z:   if (last) state_d = CS_UPDATE;
			CS_UPDATE: if (last) state_d = CS_LVL_X;
			CS_LVL_X:  if (last) state_d = CS_LVL_Y;
			CS_LVL_Y:  if (last) state_d = CS_LVL_Z;
			CS_LVL_Z:  if (last) state_d = CS_IDLE;
			default:   state_d = CS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		// a tick is taken only when the output word is free or leaving
		in_ready  = (state_q == CS_IDLE) && (!out_valid_q || out_ready);
		cmd.tick  = accept;
		cmd.load  = (state_q != CS_IDLE) && (cnt_q == '0);
		cmd.run   = (state_q != CS_IDLE) && (cnt_q != '0) && !last;
		cmd.store = last;
		case (state_q)
			CS_MUL_XZ: cmd.op = OP_MUL_XZ;
			CS_MUL_XY: cmd.op = OP_MUL_XY;
			CS_DIV3:   cmd.op = OP_DIV3;
			CS_DT_X:   cmd.op = OP_DT_X;
			CS_DT_Y:   cmd.op = OP_DT_Y;
			CS_DT_Z:   cmd.op = OP_DT_Z;
			CS_UPDATE: cmd.op = OP_UPDATE;
			CS_LVL_X:  cmd.op = OP_LVL_X;
			CS_LVL_Y:  cmd.op = OP_LVL_Y;
			CS_LVL_Z:  cmd.op = OP_LVL_Z;
			default:   cmd.op = OP_NONE;
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q || state_q == CS_IDLE) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
			if ((accept && !stat.fire) || (state_q == CS_LVL_Z && last)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/lcl_datapath.sv =====
// attractor state, tick counter, serial multipliers and held levels
`timescale 1ns / 1ps
`default_nettype none
module lcl_datapath #(
	parameter int FRAC_BITS   = lcl_pkg::FRAC_BITS_DEF,
	parameter int STATE_WIDTH = lcl_pkg::STATE_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lcl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [lcl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic [lcl_pkg::RATE_W-1:0]      rate_setting,
	input  wire lcl_pkg::cmd_t                   cmd,
	output lcl_pkg::stat_t                       stat,
	output logic                                 stepped,
	output logic [lcl_pkg::LEVEL_W-1:0]          level_x,
	output logic [lcl_pkg::LEVEL_W-1:0]          level_y,
	output logic [lcl_pkg::LEVEL_W-1:0]          level_z
);
	import lcl_pkg::*;

	localparam int W   = STATE_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int SW  = W + 32;
	localparam int NW  = ((W > F + 6) ? W : F + 6) + 1;
	localparam int PW  = NW + 8;
	localparam int DVW = F + 6;
	localparam int MW  = DVW + 9;
	localparam int LK  = 2 * DVW;
	localparam int SHL = (F >= 16) ? F - 16 : 0;
	localparam int SHR = (F < 16) ? 16 - F : 0;

	localparam logic signed [SW-1:0] VMAX_E = SW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [SW-1:0] VMIN_E = -VMAX_E - SW'(1);
	localparam logic signed [SW-1:0] RND    = (SW'(1) <<< SHR) - SW'(1);
	localparam logic [SW-1:0]        ONE_E  = SW'(1);
	// ceil(2^(W+1) / 3): exact quotient by three for any W-bit magnitude
	localparam logic [W-1:0]         DIV3_M = W'(((ONE_E << (W + 1)) + SW'(2)) / SW'(3));

	localparam logic signed [NW-1:0] OFF_X = NW'(qmicro(X_OFF_MICRO, F));
	localparam logic signed [NW-1:0] OFF_Y = NW'(qmicro(Y_OFF_MICRO, F));
	localparam logic [DVW-1:0] RNG_X = DVW'(qmicro(X_RNG_MICRO, F));
	localparam logic [DVW-1:0] RNG_Y = DVW'(qmicro(Y_RNG_MICRO, F));
	localparam logic [DVW-1:0] RNG_Z = DVW'(qmicro(Z_RNG_MICRO, F));
	localparam logic [PW-1:0]  LIM_X = PW'(RNG_X) << LEVEL_W;
	localparam logic [PW-1:0]  LIM_Y = PW'(RNG_Y) << LEVEL_W;
	localparam logic [PW-1:0]  LIM_Z = PW'(RNG_Z) << LEVEL_W;

	// ceil(255 * 2^LK / range), exact for numerators below 2^DVW
	function automatic logic [MW-1:0] lvl_recip(input logic [DVW-1:0] r);
		logic [127:0] n;
		n = (128'd255 << LK) + 128'(r) - 128'd1;
		return MW'(n / 128'(r));
	endfunction

	localparam logic [MW-1:0] REC_X = lvl_recip(RNG_X);
	localparam logic [MW-1:0] REC_Y = lvl_recip(RNG_Y);
	localparam logic [MW-1:0] REC_Z = lvl_recip(RNG_Z);

	function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] c;
		c = v;
		if (v > VMAX_E) c = VMAX_E;
		if (v < VMIN_E) c = VMIN_E;
		return $signed(c[W-1:0]);
	endfunction

	function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	// q8.16 start value to the internal format, truncated toward zero
	function automatic logic signed [W-1:0] conv_y(input logic [INITY_W-1:0] iy);
		logic signed [SW-1:0] e;
		e = SW'($signed(iy)) <<< SHL;
		if (e < 0) e = e + RND;
		e = e >>> SHR;
		return sat_w(e);
	endfunction

	logic signed [W-1:0]   pos_x_q, pos_y_q, pos_z_q;
	logic [STEP_W-1:0]     step_q;
	logic [RATE_W-1:0]     tick_q;
	logic                  stepped_q;
	logic [LEVEL_W-1:0]    lx_q, ly_q, lz_q;

	logic signed [W-1:0]   mxz_q, mxy_q, dx_q, dy_q, dz_q;
	logic signed [W+2:0]   z83_q;

	// shift-add multiplier
	logic [W-1:0]          ma_q, mhi_q, mlo_q;
	logic                  mneg_q;
	// level multiplier by the reciprocal of the range
	logic [MW-1:0]         lm_q, lhi_q;
	logic [DVW-1:0]        llo_q;
	logic                  lzero_q, lfull_q;

	logic signed [SW-1:0]  dxy, x_e, y_e;
	logic signed [W-1:0]   t_x, t_y, t_z, t_sel;
	logic [W-1:0]          ld_a, ld_b;
	logic                  ld_neg;
	logic [W:0]            msum;
	logic [2*W-1:0]        mprod;
	logic [2*W-F-1:0]      mshr;
	logic [W-1:0]          mlim, mmag, dtmag;
	logic signed [W-1:0]   mulq_res, dt_res;
	logic [W-2:0]          q3;
	logic [W:0]            q3x3;
	logic [1:0]            r3;
	logic [2:0]            adj3;
	logic [W+2:0]          mag83;
	logic signed [W-1:0]   lv;
	logic signed [NW-1:0]  loff, num;
	logic [MW-1:0]         lrec;
	logic [PW-1:0]         llim, prod;
	logic [MW:0]           lsum;
	logic [LEVEL_W-1:0]    lres;

	assign stat.fire = tick_q > rate_setting;

	// terms of the derivatives
	always_comb begin
		x_e = SW'(pos_x_q);
		y_e = SW'(pos_y_q);
		dxy = y_e - x_e;
		t_x = sat_w((dxy <<< 3) + (dxy <<< 1));
		t_y = sat_w((x_e <<< 5) - (x_e <<< 2) - y_e - SW'(mxz_q));
		t_z = sat_w(SW'(mxy_q) - SW'(z83_q));
	end

	// multiplier operands per op
	always_comb begin
		t_sel  = t_x;
		ld_a   = abs_w(pos_x_q);
		ld_b   = abs_w(pos_z_q);
		ld_neg = pos_x_q[W-1] ^ pos_z_q[W-1];
		case (cmd.op)
			OP_MUL_XY: begin
				ld_b   = abs_w(pos_y_q);
				ld_neg = pos_x_q[W-1] ^ pos_y_q[W-1];
			end
			OP_DIV3: begin
				ld_a   = abs_w(pos_z_q);
				ld_b   = DIV3_M;
				ld_neg = pos_z_q[W-1];
			end
			OP_DT_X, OP_DT_Y, OP_DT_Z: begin
				if (cmd.op == OP_DT_Y) t_sel = t_y;
				else if (cmd.op == OP_DT_Z) t_sel = t_z;
				ld_a   = abs_w(t_sel);
				ld_b   = W'(step_q);
				ld_neg = t_sel[W-1];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		msum  = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, ma_q} : '0);
		mprod = {mhi_q, mlo_q};
		mshr  = mprod[2*W-1:F];
		mlim  = mneg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		mmag  = (mshr > (2*W-F)'(mlim)) ? mlim : mshr[W-1:0];
		mulq_res = mneg_q ? $signed(-mmag) : $signed(mmag);
		// after the short run the high half is already the product over 2^16
		dtmag  = mhi_q;
		dt_res = mneg_q ? $signed(-dtmag) : $signed(dtmag);
	end

	// 8|z|/3 from |z|/3 and the remainder: 8q + floor(8r/3)
	always_comb begin
		q3   = mhi_q[W-1:1];
		q3x3 = {1'b0, q3, 1'b0} + {2'b00, q3};
		r3   = 2'(ma_q - q3x3[W-1:0]);
		case (r3)
			2'd1:    adj3 = 3'd2;
			2'd2:    adj3 = 3'd5;
			default: adj3 = 3'd0;
		endcase
		mag83 = {1'b0, q3, 3'b000} + (W+3)'(adj3);
	end

	// level scaling setup and multiplier step
	always_comb begin
		case (cmd.op)
			OP_LVL_Y: begin
				lv = pos_y_q; loff = OFF_Y; lrec = REC_Y; llim = LIM_Y;
			end
			OP_LVL_Z: begin
				lv = pos_z_q; loff = '0; lrec = REC_Z; llim = LIM_Z;
			end
			default: begin
				lv = pos_x_q; loff = OFF_X; lrec = REC_X; llim = LIM_X;
			end
		endcase
		num  = NW'(lv) + loff;
		prod = (PW'(num) << LEVEL_W) - PW'(num);
		lsum = {1'b0, lhi_q} + (llo_q[0] ? {1'b0, lm_q} : '0);
		lres = lzero_q ? '0 : (lfull_q ? LEVEL_MAX : lhi_q[DVW+LEVEL_W-1:DVW]);
	end

	// configuration, attractor state and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_RESET;
			pos_x_q   <= '0;
			pos_y_q   <= conv_y(INITY_RESET);
			pos_z_q   <= '0;
			tick_q    <= '0;
			stepped_q <= 1'b0;
			lx_q      <= '0;
			ly_q      <= '0;
			lz_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					CFG_STEP_SIZE: step_q <= cfg_wdata[STEP_W-1:0];
					CFG_INITIAL_Y: begin
						pos_x_q <= '0;
						pos_y_q <= conv_y(cfg_wdata[INITY_W-1:0]);
						pos_z_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.tick) begin
				stepped_q <= stat.fire;
				tick_q    <= stat.fire ? '0 : tick_q + RATE_W'(1);
			end
			if (cmd.store) begin
				case (cmd.op)
					OP_UPDATE: begin
						pos_x_q <= sat_w(x_e + SW'(dx_q));
						pos_y_q <= sat_w(y_e + SW'(dy_q));
						pos_z_q <= sat_w(SW'(pos_z_q) + SW'(dz_q));
					end
					OP_LVL_X: lx_q <= lres;
					OP_LVL_Y: ly_q <= lres;
					OP_LVL_Z: lz_q <= lres;
					default: begin
					end
				endcase
			end
		end
	end

	// arithmetic units and step temporaries
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ma_q    <= ld_a;
			mhi_q   <= '0;
			mlo_q   <= ld_b;
			mneg_q  <= ld_neg;
			lzero_q <= num[NW-1] || (num == '0);
			lfull_q <= prod >= llim;
			lm_q    <= lrec;
			lhi_q   <= '0;
			llo_q   <= num[DVW-1:0];
		end else if (cmd.run) begin
			mhi_q  <= msum[W:1];
			mlo_q  <= {msum[0], mlo_q[W-1:1]};
			lhi_q  <= lsum[MW:1];
			llo_q  <= {lsum[0], llo_q[DVW-1:1]};
		end
		if (cmd.store) begin
			case (cmd.op)
				OP_MUL_XZ: mxz_q <= mulq_res;
				OP_MUL_XY: mxy_q <= mulq_res;
				OP_DIV3:   z83_q <= mneg_q ? $signed(-mag83) : $signed(mag83);
				OP_DT_X:   dx_q  <= dt_res;
				OP_DT_Y:   dy_q  <= dt_res;
				OP_DT_Z:   dz_q  <= dt_res;
				default: begin
				end
			endcase
		end
	end

	assign stepped = stepped_q;
	assign level_x = lx_q;
	assign level_y = ly_q;
	assign level_z = lz_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lorenz_chaotic_lfo.sv =====
// top level of the lorenz chaotic lfo
`timescale 1ns / 1ps
`default_nettype none
// Each accepted word is one tick carrying rate_setting; every tick returns one word with the
// held x, y and z levels (0..255) and a stepped flag. A tick that does not fire a step gives
// its word in the cycle after acceptance. A firing tick runs one Euler step of the Lorenz system
// through a shared shift-add multiplier (the divide by three is a reciprocal multiply) and a
// second shift-add multiplier for the level scaling, one bit per cycle; its word is offered once
// the z level, the last of the three, is stored. Ticks are taken one at a time while the output
// word is free or being taken. Config writes (step_size at index 0, initial_y at index 1) are
// applied at once; initial_y restarts the attractor.
module lorenz_chaotic_lfo #(
	parameter int FRAC_BITS   = lcl_pkg::FRAC_BITS_DEF,
	parameter int STATE_WIDTH = lcl_pkg::STATE_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lcl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [lcl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [lcl_pkg::RATE_W-1:0]      rate_setting,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 stepped,
	output logic [lcl_pkg::LEVEL_W-1:0]          level_x,
	output logic [lcl_pkg::LEVEL_W-1:0]          level_y,
	output logic [lcl_pkg::LEVEL_W-1:0]          level_z
);
	import lcl_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lcl_ctrl #(
		.FRAC_BITS   (FRAC_BITS),
		.STATE_WIDTH (STATE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lcl_datapath #(
		.FRAC_BITS   (FRAC_BITS),
		.STATE_WIDTH (STATE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.rate_setting (rate_setting),
		.cmd          (cmd),
		.stat         (stat),
		.stepped      (stepped),
		.level_x      (level_x),
		.level_y      (level_y),
		.level_z      (level_z)
	);

endmodule
`default_nettype wire
